### src/panel_frame_capture_cmd_inject_macros.svh
// ----------------------------------------------------------------------------
// panel frame capture assertion macros
// shared concurrent check wrappers, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef PANEL_FRAME_CAPTURE_CMD_INJECT_MACROS_SVH
`define PANEL_FRAME_CAPTURE_CMD_INJECT_MACROS_SVH

`ifndef SYNTH
`define PFCI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define PFCI_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define PFCI_ASSERT(label, prop, msg)
`define PFCI_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

### src/pfci_pkg.sv
// ----------------------------------------------------------------------------
// pfci_pkg
// types, constants and lookup functions for the panel frame capture block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfci_pkg;

	localparam int unsigned FRAME_LEN    = 42;
	localparam int unsigned INJECT_FIRST = 39;
	localparam int unsigned INJECT_LAST  = 41;

	localparam logic [6:0] UNKNOWN_CHAR = 7'h2D;

	localparam logic [1:0] CFG_GAP_LIMIT   = 2'd0;
	localparam logic [1:0] CFG_PRESS_COUNT = 2'd1;
	localparam logic [1:0] CFG_CAPTURE_EN  = 2'd2;

	localparam logic [15:0] GAP_LIMIT_RST   = 16'd2000;
	localparam logic [7:0]  PRESS_COUNT_RST = 8'd8;

	typedef enum logic [1:0] {
		OP_EDGE  = 2'd0,
		OP_PRESS = 2'd1,
		OP_REARM = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		BTN_NONE   = 3'd0,
		BTN_MODE   = 3'd1,
		BTN_UP     = 3'd2,
		BTN_DOWN   = 3'd3,
		BTN_LAMP   = 3'd4,
		BTN_JETS_A = 3'd5,
		BTN_JETS_B = 3'd6,
		BTN_AIR    = 3'd7
	} cmd_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] edge_gap_us;
		logic        display_bit;
		logic        control_bit;
		logic [2:0]  command_code;
	} item_t;

	typedef struct packed {
		logic        drive_level;
		logic        frame_done;
		logic [41:0] display_frame;
		logic [41:0] control_frame;
		logic [6:0]  char_one;
		logic [6:0]  char_two;
		logic [6:0]  char_three;
		logic [6:0]  char_four;
		logic        press_done;
	} result_t;

	// bus code sent for each command, msb first
	function automatic logic [2:0] cmd_bus_code(input logic [2:0] cmd);
		logic [2:0] code;
		case (cmd_t'(cmd))
			BTN_NONE:   code = 3'b000;
			BTN_MODE:   code = 3'b001;
			BTN_UP:     code = 3'b100;
			BTN_DOWN:   code = 3'b101;
			BTN_LAMP:   code = 3'b011;
			BTN_JETS_A: code = 3'b110;
			BTN_JETS_B: code = 3'b010;
			BTN_AIR:    code = 3'b111;
			default:    code = 3'b000;
		endcase
		return code;
	endfunction

	function automatic logic [6:0] seg_to_ascii(input logic [6:0] seg);
		logic [6:0] ch;
		case (seg)
			7'h00: ch = 7'h20;
			7'h7E: ch = 7'h30;
			7'h30: ch = 7'h31;
			7'h6D: ch = 7'h32;
			7'h79: ch = 7'h33;
			7'h33: ch = 7'h34;
			7'h5B: ch = 7'h35;
			7'h5F: ch = 7'h36;
			7'h70: ch = 7'h37;
			7'h7F: ch = 7'h38;
			7'h73: ch = 7'h39;
			7'h77: ch = 7'h41;
			7'h4E: ch = 7'h43;
			7'h4F: ch = 7'h45;
			7'h5E: ch = 7'h47;
			7'h37: ch = 7'h48;
			7'h3C: ch = 7'h4A;
			7'h0E: ch = 7'h4C;
			7'h54: ch = 7'h4D;
			7'h76: ch = 7'h4E;
			7'h6B: ch = 7'h51;
			7'h66: ch = 7'h52;
			7'h3E: ch = 7'h55;
			7'h2A: ch = 7'h57;
			7'h7D: ch = 7'h61;
			7'h1F: ch = 7'h62;
			7'h0D: ch = 7'h63;
			7'h3D: ch = 7'h64;
			7'h6F: ch = 7'h65;
			7'h47: ch = 7'h66;
			7'h17: ch = 7'h68;
			7'h04: ch = 7'h69;
			7'h01: ch = 7'h6A;
			7'h57: ch = 7'h6B;
			7'h06: ch = 7'h6C;
			7'h14: ch = 7'h6D;
			7'h15: ch = 7'h6E;
			7'h1D: ch = 7'h6F;
			7'h67: ch = 7'h70;
			7'h05: ch = 7'h72;
			7'h0F: ch = 7'h74;
			7'h1C: ch = 7'h75;
			7'h3B: ch = 7'h79;
			default: ch = UNKNOWN_CHAR;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

### src/panel_frame_capture_cmd_inject.sv
// ----------------------------------------------------------------------------
// panel_frame_capture_cmd_inject
// spa topside bus frame capture with command injection on the control line
// ----------------------------------------------------------------------------
// Takes one item per clock cycle, back to back, and returns exactly one result
// per item, in order. Each item passes an input register, the capture logic,
// and a result register, so a result is offered once its item has moved from
// the input register into the result register; the result register lets
// a new item in while a result still waits for out_ready, and the input stalls
// only when both registers are full and out_ready is low. Config writes take
// effect at the edge that writes them and should be made while no item is in
// flight.
`timescale 1ns / 1ps
`default_nettype none

`include "panel_frame_capture_cmd_inject_macros.svh"

module panel_frame_capture_cmd_inject (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [15:0] edge_gap_us,
	input  wire logic        display_bit,
	input  wire logic        control_bit,
	input  wire logic [2:0]  command_code,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             drive_level,
	output logic             frame_done,
	output logic [41:0]      display_frame,
	output logic [41:0]      control_frame,
	output logic [6:0]       char_one,
	output logic [6:0]       char_two,
	output logic [6:0]       char_three,
	output logic [6:0]       char_four,
	output logic             press_done
);

	logic                vld_s1;
	logic                vld_s2;
	pfci_pkg::item_t     item_s1;
	pfci_pkg::result_t   res_s2;
	pfci_pkg::result_t   res;
	logic                adv;
	logic                fire;

	assign adv      = !vld_s2 || out_ready;
	assign fire     = vld_s1 && adv;
	assign in_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				vld_s1 <= 1'b1;
			else if (fire)
				vld_s1 <= 1'b0;
			if (fire)
				vld_s2 <= 1'b1;
			else if (out_ready)
				vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.op           <= op;
			item_s1.edge_gap_us  <= edge_gap_us;
			item_s1.display_bit  <= display_bit;
			item_s1.control_bit  <= control_bit;
			item_s1.command_code <= command_code;
		end
		if (fire)
			res_s2 <= res;
	end

	pfci_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.upd       (fire),
		.item      (item_s1),
		.res       (res)
	);

	assign out_valid     = vld_s2;
	assign drive_level   = res_s2.drive_level;
	assign frame_done    = res_s2.frame_done;
	assign display_frame = res_s2.display_frame;
	assign control_frame = res_s2.control_frame;
	assign char_one      = res_s2.char_one;
	assign char_two      = res_s2.char_two;
	assign char_three    = res_s2.char_three;
	assign char_four     = res_s2.char_four;
	assign press_done    = res_s2.press_done;

	`PFCI_ASSERT(a_stall_cause, !in_ready |-> vld_s1 && vld_s2 && !out_ready, "input stalled without a blocked result")
	`PFCI_ASSERT_NEXT(a_fire_result, fire, vld_s2, "processed item produced no result")
	`PFCI_ASSERT_NEXT(a_held_item, vld_s1 && !adv, vld_s1, "waiting item dropped")

endmodule

`default_nettype wire

### src/pfci_char_dec.sv
// ----------------------------------------------------------------------------
// pfci_char_dec
// decodes the four seven-segment digits of a display frame to ascii
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfci_char_dec (
	input  wire logic [41:0] frame,
	output logic      [6:0]  char_one,
	output logic      [6:0]  char_two,
	output logic      [6:0]  char_three,
	output logic      [6:0]  char_four
);

	assign char_one   = pfci_pkg::seg_to_ascii(frame[41:35]);
	assign char_two   = pfci_pkg::seg_to_ascii(frame[34:28]);
	assign char_three = pfci_pkg::seg_to_ascii(frame[27:21]);
	assign char_four  = pfci_pkg::seg_to_ascii(frame[20:14]);

endmodule

`default_nettype wire

### src/pfci_core.sv
// ----------------------------------------------------------------------------
// pfci_core
// capture state, config registers and the single-pass item logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "panel_frame_capture_cmd_inject_macros.svh"

module pfci_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [15:0]         cfg_data,
	input  wire logic                upd,
	input  wire pfci_pkg::item_t     item,
	output pfci_pkg::result_t        res
);

	localparam logic [5:0] LAST_IDX  = 6'(pfci_pkg::FRAME_LEN - 1);
	localparam logic [5:0] FRAME_IDX = 6'(pfci_pkg::FRAME_LEN);
	localparam logic [5:0] INJ_FIRST = 6'(pfci_pkg::INJECT_FIRST);
	localparam logic [5:0] INJ_LAST  = 6'(pfci_pkg::INJECT_LAST);

	logic [15:0] gap_limit_q;
	logic [7:0]  press_count_q;
	logic        cap_en_q;

	logic [5:0]  idx_q;
	logic        frozen_q;
	logic [41:0] dsh_q;
	logic [41:0] csh_q;
	logic        press_q;
	logic [2:0]  cmd_q;
	logic [7:0]  left_q;
	logic        held_q;

	pfci_pkg::op_t op;
	logic        is_edge;
	logic        long_gap;
	logic [5:0]  idx_eff;
	logic        frz_eff;
	logic        sample;
	logic        done;
	logic [2:0]  code;
	logic        level;
	logic [41:0] dsh_n;
	logic [41:0] csh_n;
	logic [7:0]  left_dec;
	logic        pdone;
	logic        press_start;
	logic [6:0]  ch1, ch2, ch3, ch4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q   <= pfci_pkg::GAP_LIMIT_RST;
			press_count_q <= pfci_pkg::PRESS_COUNT_RST;
			cap_en_q      <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				pfci_pkg::CFG_GAP_LIMIT:   gap_limit_q   <= cfg_data;
				pfci_pkg::CFG_PRESS_COUNT: press_count_q <= cfg_data[7:0];
				pfci_pkg::CFG_CAPTURE_EN:  cap_en_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		op          = pfci_pkg::op_t'(item.op);
		press_start = (op == pfci_pkg::OP_PRESS) && (item.command_code != pfci_pkg::BTN_NONE);
		is_edge     = (op == pfci_pkg::OP_EDGE) && cap_en_q;
		long_gap    = item.edge_gap_us > gap_limit_q;
		idx_eff     = long_gap ? 6'd0 : idx_q;
		frz_eff     = long_gap ? 1'b0 : frozen_q;
		sample      = is_edge && !frz_eff && (idx_eff < FRAME_IDX);
		done        = sample && (idx_eff == LAST_IDX);
		code        = pfci_pkg::cmd_bus_code(cmd_q);
		level       = 1'b1;
		if (press_q && idx_eff >= INJ_FIRST) begin
			if (idx_eff == INJ_FIRST)
				level = code[2];
			else if (idx_eff == INJ_LAST)
				level = code[0];
			else
				level = code[1];
		end
		dsh_n    = {dsh_q[40:0], item.display_bit};
		csh_n    = {csh_q[40:0], item.control_bit};
		left_dec = (left_q != 8'd0) ? left_q - 8'd1 : 8'd0;
		pdone    = done && press_q && (left_dec == 8'd0);
	end

	pfci_char_dec u_char_dec (
		.frame      (dsh_n),
		.char_one   (ch1),
		.char_two   (ch2),
		.char_three (ch3),
		.char_four  (ch4)
	);

	always_comb begin
		res               = '0;
		res.drive_level   = sample ? level : held_q;
		res.frame_done    = done;
		res.press_done    = pdone;
		if (done) begin
			res.display_frame = dsh_n;
			res.control_frame = csh_n;
			res.char_one      = ch1;
			res.char_two      = ch2;
			res.char_three    = ch3;
			res.char_four     = ch4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			frozen_q <= 1'b0;
			dsh_q    <= '0;
			csh_q    <= '0;
			press_q  <= 1'b0;
			cmd_q    <= pfci_pkg::BTN_NONE;
			left_q   <= '0;
			held_q   <= 1'b1;
		end else if (upd) begin
			if (press_start) begin
				cmd_q   <= item.command_code;
				left_q  <= press_count_q;
				press_q <= 1'b1;
			end
			if (op == pfci_pkg::OP_REARM) begin
				idx_q    <= '0;
				frozen_q <= 1'b0;
			end
			if (is_edge) begin
				idx_q    <= idx_eff;
				frozen_q <= frz_eff;
			end
			if (sample) begin
				held_q <= level;
				dsh_q  <= dsh_n;
				csh_q  <= csh_n;
				idx_q  <= idx_eff + 6'd1;
				if (done) begin
					frozen_q <= 1'b1;
					if (press_q) begin
						left_q <= left_dec;
						if (left_dec == 8'd0) begin
							press_q <= 1'b0;
							cmd_q   <= pfci_pkg::BTN_NONE;
						end
					end
				end
			end
		end
	end

	`PFCI_ASSERT(a_idx_range, idx_q <= FRAME_IDX, "sample index beyond frame length")
	`PFCI_ASSERT_NEXT(a_done_freezes, upd && res.frame_done, frozen_q && idx_q == FRAME_IDX, "no freeze")
	`PFCI_ASSERT_NEXT(a_press_end, upd && res.press_done, !press_q, "press did not end")
	`PFCI_ASSERT(a_idle_cmd, !press_q |-> cmd_q == pfci_pkg::BTN_NONE, "command without a press")

endmodule

`default_nettype wire

### dv/panel_frame_capture_cmd_inject_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// panel_frame_capture_cmd_inject_test
// drives clock edges, press starts and re-arms into the frame capture block,
// predicts every result from its own model of the capture, injection and
// seven-segment decode, and checks the results in order under random idling
// and back-pressure across several register settings
// ----------------------------------------------------------------------------

module panel_frame_capture_cmd_inject_test;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned LONG_HOLD = 150;

	class frame_scoreboard;
		logic [15:0] gap_limit;
		logic [7:0]  press_count;
		logic        capture_on;
		logic [5:0]  sample_idx;
		logic        frozen;
		logic [41:0] display_sr;
		logic [41:0] control_sr;
		logic        press_on;
		pfci_pkg::cmd_t press_cmd;
		logic [7:0]  presses_left;
		logic        line_level;
		pfci_pkg::result_t expected_results[$];
		int          mismatches;
		int          results_seen;

		function new();
			gap_limit = pfci_pkg::GAP_LIMIT_RST;
			press_count = pfci_pkg::PRESS_COUNT_RST;
			capture_on = 1'b1;
			sample_idx = '0;
			frozen = 1'b0;
			display_sr = '0;
			control_sr = '0;
			press_on = 1'b0;
			press_cmd = pfci_pkg::BTN_NONE;
			presses_left = '0;
			line_level = 1'b1;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [15:0] val);
			case (idx)
				pfci_pkg::CFG_GAP_LIMIT:   gap_limit = val;
				pfci_pkg::CFG_PRESS_COUNT: press_count = val[7:0];
				pfci_pkg::CFG_CAPTURE_EN:  capture_on = val[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// segment pattern in the upper half, ascii in the lower half
		function logic [13:0] glyph(int k);
			case (k)
				0:  return {7'h00, 7'h20};
				1:  return {7'h7E, 7'h30};
				2:  return {7'h30, 7'h31};
				3:  return {7'h6D, 7'h32};
				4:  return {7'h79, 7'h33};
				5:  return {7'h33, 7'h34};
				6:  return {7'h5B, 7'h35};
				7:  return {7'h5F, 7'h36};
				8:  return {7'h70, 7'h37};
				9:  return {7'h7F, 7'h38};
				10: return {7'h73, 7'h39};
				11: return {7'h77, 7'h41};
				12: return {7'h4E, 7'h43};
				13: return {7'h4F, 7'h45};
				14: return {7'h5E, 7'h47};
				15: return {7'h37, 7'h48};
				16: return {7'h3C, 7'h4A};
				17: return {7'h0E, 7'h4C};
				18: return {7'h54, 7'h4D};
				19: return {7'h76, 7'h4E};
				20: return {7'h6B, 7'h51};
				21: return {7'h66, 7'h52};
				22: return {7'h3E, 7'h55};
				23: return {7'h2A, 7'h57};
				24: return {7'h7D, 7'h61};
				25: return {7'h1F, 7'h62};
				26: return {7'h0D, 7'h63};
				27: return {7'h3D, 7'h64};
				28: return {7'h6F, 7'h65};
				29: return {7'h47, 7'h66};
				30: return {7'h17, 7'h68};
				31: return {7'h04, 7'h69};
				32: return {7'h01, 7'h6A};
				33: return {7'h57, 7'h6B};
				34: return {7'h06, 7'h6C};
				35: return {7'h14, 7'h6D};
				36: return {7'h15, 7'h6E};
				37: return {7'h1D, 7'h6F};
				38: return {7'h67, 7'h70};
				39: return {7'h05, 7'h72};
				40: return {7'h0F, 7'h74};
				41: return {7'h1C, 7'h75};
				42: return {7'h3B, 7'h79};
				default: return {7'h7F, pfci_pkg::UNKNOWN_CHAR};
			endcase
		endfunction

		function logic [6:0] digit_char(logic [6:0] pattern);
			logic [13:0] g;
			for (int k = 0; k < 43; k++) begin
				g = glyph(k);
				if (g[13:7] == pattern) return g[6:0];
			end
			return pfci_pkg::UNKNOWN_CHAR;
		endfunction

		function logic [2:0] bus_code(pfci_pkg::cmd_t c);
			case (c)
				pfci_pkg::BTN_MODE:   return 3'b001;
				pfci_pkg::BTN_UP:     return 3'b100;
				pfci_pkg::BTN_DOWN:   return 3'b101;
				pfci_pkg::BTN_LAMP:   return 3'b011;
				pfci_pkg::BTN_JETS_A: return 3'b110;
				pfci_pkg::BTN_JETS_B: return 3'b010;
				pfci_pkg::BTN_AIR:    return 3'b111;
				default:              return 3'b000;
			endcase
		endfunction

		function void note_item(pfci_pkg::item_t it);
			pfci_pkg::result_t r;
			logic [2:0] code;
			r = '0;
			case (it.op)
				pfci_pkg::OP_PRESS: begin
					if (pfci_pkg::cmd_t'(it.command_code) != pfci_pkg::BTN_NONE) begin
						press_cmd = pfci_pkg::cmd_t'(it.command_code);
						presses_left = press_count;
						press_on = 1'b1;
					end
				end
				pfci_pkg::OP_REARM: begin
					sample_idx = '0;
					frozen = 1'b0;
				end
				pfci_pkg::OP_EDGE: begin
					if (capture_on) begin
						if (it.edge_gap_us > gap_limit) begin
							sample_idx = '0;
							frozen = 1'b0;
						end
						if (!frozen && sample_idx < pfci_pkg::FRAME_LEN) begin
							line_level = 1'b1;
							if (press_on && sample_idx >= pfci_pkg::INJECT_FIRST
									&& sample_idx <= pfci_pkg::INJECT_LAST) begin
								code = bus_code(press_cmd);
								line_level = code[pfci_pkg::INJECT_LAST - sample_idx];
							end
							display_sr = {display_sr[40:0], it.display_bit};
							control_sr = {control_sr[40:0], it.control_bit};
							sample_idx = sample_idx + 6'd1;
							if (sample_idx >= pfci_pkg::FRAME_LEN) begin
								frozen = 1'b1;
								r.frame_done = 1'b1;
								r.display_frame = display_sr;
								r.control_frame = control_sr;
								r.char_one = digit_char(display_sr[41:35]);
								r.char_two = digit_char(display_sr[34:28]);
								r.char_three = digit_char(display_sr[27:21]);
								r.char_four = digit_char(display_sr[20:14]);
								if (press_on) begin
									if (presses_left != 0) presses_left = presses_left - 8'd1;
									if (presses_left == 0) begin
										press_on = 1'b0;
										press_cmd = pfci_pkg::BTN_NONE;
										r.press_done = 1'b1;
									end
								end
							end
						end
					end
				end
				default: ;
			endcase
			r.drive_level = line_level;
			expected_results = {expected_results, r};
		endfunction

		function string field_diffs(pfci_pkg::result_t w, pfci_pkg::result_t g);
			string s;
			s = "";
			if (w.drive_level !== g.drive_level) s = {s, " drive_level"};
			if (w.frame_done !== g.frame_done) s = {s, " frame_done"};
			if (w.display_frame !== g.display_frame) s = {s, " display_frame"};
			if (w.control_frame !== g.control_frame) s = {s, " control_frame"};
			if (w.char_one !== g.char_one) s = {s, " char_one"};
			if (w.char_two !== g.char_two) s = {s, " char_two"};
			if (w.char_three !== g.char_three) s = {s, " char_three"};
			if (w.char_four !== g.char_four) s = {s, " char_four"};
			if (w.press_done !== g.press_done) s = {s, " press_done"};
			return s;
		endfunction

		function void show(string tag, pfci_pkg::result_t r);
			$display("  %s: drive %b done %b disp %h ctrl %h chars %h %h %h %h press %b",
				tag, r.drive_level, r.frame_done, r.display_frame, r.control_frame,
				r.char_one, r.char_two, r.char_three, r.char_four, r.press_done);
		endfunction

		function void check_result(pfci_pkg::result_t got);
			pfci_pkg::result_t want;
			string diffs;
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result %0d arrived with nothing expected", results_seen);
					show("actual", got);
				end
				return;
			end
			want = expected_results.pop_front();
			diffs = field_diffs(want, got);
			if (diffs != "") begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result %0d mismatch in%s", results_seen, diffs);
					show("expected", want);
					show("actual", got);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = '0;
	logic [15:0] edge_gap_us = '0;
	logic display_bit = 1'b0;
	logic control_bit = 1'b0;
	logic [2:0] command_code = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic drive_level;
	logic frame_done;
	logic [41:0] display_frame;
	logic [41:0] control_frame;
	logic [6:0] char_one;
	logic [6:0] char_two;
	logic [6:0] char_three;
	logic [6:0] char_four;
	logic press_done;

	frame_scoreboard sb = new();
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit rx_hold_req = 1'b0;
	int items_sent = 0;
	int unsigned cycle_count = 0;

	panel_frame_capture_cmd_inject i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.edge_gap_us   (edge_gap_us),
		.display_bit   (display_bit),
		.control_bit   (control_bit),
		.command_code  (command_code),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.drive_level   (drive_level),
		.frame_done    (frame_done),
		.display_frame (display_frame),
		.control_frame (control_frame),
		.char_one      (char_one),
		.char_two      (char_two),
		.char_three    (char_three),
		.char_four     (char_four),
		.press_done    (press_done)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("panel_frame_capture_cmd_inject test failed");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] op_v, input logic [15:0] gap, input logic d,
			input logic c, input logic [2:0] cmd);
		int pause;
		pfci_pkg::item_t it;
		pause = tx_idle_on ? int'($urandom_range(0, 13)) : 0;
		if (pause > 0) begin
			in_valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= op_v;
		edge_gap_us <= gap;
		display_bit <= d;
		control_bit <= c;
		command_code <= cmd;
		it.op = op_v;
		it.edge_gap_us = gap;
		it.display_bit = d;
		it.control_bit = c;
		it.command_code = cmd;
		do @(posedge clk); while (!(in_valid && in_ready));
		sb.note_item(it);
		items_sent++;
	endtask

	task automatic send_noise();
		send_item(2'($urandom_range(0, 3)), 16'($urandom), 1'($urandom), 1'($urandom),
			3'($urandom));
	endtask

	// one frame: a start, then edges with short gaps, sometimes cut short
	task automatic send_frame();
		logic [41:0] disp;
		logic [41:0] ctrl;
		logic [13:0] g;
		logic [15:0] lim;
		logic [15:0] gap;
		int stop_at;
		lim = sb.gap_limit;
		disp = 42'({$urandom, $urandom});
		ctrl = 42'({$urandom, $urandom});
		if ($urandom_range(0, 1) == 1) begin
			for (int d = 0; d < 4; d++) begin
				g = sb.glyph(int'($urandom_range(0, 42)));
				disp[41 - 7 * d -: 7] = g[13:7];
			end
		end
		if ($urandom_range(0, 3) == 0)
			send_item(pfci_pkg::OP_PRESS, 16'($urandom), 1'($urandom), 1'($urandom),
				3'($urandom_range(0, 7)));
		if ($urandom_range(0, 15) == 0) send_noise();
		stop_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 41))
			: int'(pfci_pkg::FRAME_LEN);
		for (int k = 0; k < int'(pfci_pkg::FRAME_LEN); k++) begin
			if (k == stop_at) return;
			if (k == 0) begin
				if (lim == 16'hFFFF || $urandom_range(0, 7) == 0) begin
					send_item(pfci_pkg::OP_REARM, 16'($urandom), 1'($urandom), 1'($urandom),
						3'($urandom));
					gap = 16'($urandom_range(0, int'(lim)));
				end else begin
					gap = 16'($urandom_range(int'(lim) + 1, 65535));
				end
			end else begin
				gap = ($urandom_range(0, 7) == 0) ? lim : 16'($urandom_range(0, int'(lim)));
			end
			send_item(pfci_pkg::OP_EDGE, gap, disp[41 - k], ctrl[41 - k], 3'($urandom));
		end
		// edges into a frozen frame
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3))
				send_item(pfci_pkg::OP_EDGE, 16'($urandom_range(0, int'(lim))), 1'($urandom),
					1'($urandom), 3'($urandom));
		end
	endtask

	task automatic run_random(input int count);
		int target;
		target = items_sent + count;
		while (items_sent < target) begin
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 7) != 0) send_frame();
			else repeat ($urandom_range(1, 3)) send_noise();
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_config(input logic [15:0] lim, input logic [7:0] cnt, input logic en);
		cfg_we <= 1'b1;
		cfg_index <= pfci_pkg::CFG_GAP_LIMIT;
		cfg_data <= lim;
		@(posedge clk);
		sb.set_register(pfci_pkg::CFG_GAP_LIMIT, lim);
		cfg_index <= pfci_pkg::CFG_PRESS_COUNT;
		cfg_data <= {8'h00, cnt};
		@(posedge clk);
		sb.set_register(pfci_pkg::CFG_PRESS_COUNT, {8'h00, cnt});
		cfg_index <= pfci_pkg::CFG_CAPTURE_EN;
		cfg_data <= {15'h0000, en};
		@(posedge clk);
		sb.set_register(pfci_pkg::CFG_CAPTURE_EN, {15'h0000, en});
		cfg_we <= 1'b0;
	endtask

	initial begin : result_side
		int stall;
		pfci_pkg::result_t got;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				stall = LONG_HOLD;
			end else begin
				stall = rx_idle_on ? int'($urandom_range(0, 13)) : 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			got = {drive_level, frame_done, display_frame, control_frame,
				char_one, char_two, char_three, char_four, press_done};
			sb.check_result(got);
		end
	end

	initial begin : stimulus
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, unused op, empty press, gap boundaries, every command
		send_item(pfci_pkg::OP_EDGE, 16'd0, 1'b1, 1'b1, pfci_pkg::BTN_NONE);
		send_item(OP_SPARE, 16'hFFFF, 1'b1, 1'b1, pfci_pkg::BTN_AIR);
		send_item(pfci_pkg::OP_PRESS, 16'd0, 1'b0, 1'b0, pfci_pkg::BTN_NONE);
		send_item(pfci_pkg::OP_EDGE, pfci_pkg::GAP_LIMIT_RST, 1'b0, 1'b1, pfci_pkg::BTN_NONE);
		send_item(pfci_pkg::OP_EDGE, pfci_pkg::GAP_LIMIT_RST + 16'd1, 1'b1, 1'b0,
			pfci_pkg::BTN_NONE);
		send_item(pfci_pkg::OP_EDGE, 16'hFFFF, 1'b0, 1'b0, pfci_pkg::BTN_NONE);
		send_item(pfci_pkg::OP_REARM, 16'hFFFF, 1'b1, 1'b1, pfci_pkg::BTN_AIR);
		send_item(pfci_pkg::OP_PRESS, 16'd0, 1'b0, 1'b0, pfci_pkg::BTN_MODE);
		send_item(pfci_pkg::OP_PRESS, 16'd0, 1'b0, 1'b0, pfci_pkg::BTN_UP);
		send_item(pfci_pkg::OP_PRESS, 16'd0, 1'b0, 1'b0, pfci_pkg::BTN_DOWN);
		send_item(pfci_pkg::OP_PRESS, 16'd0, 1'b0, 1'b0, pfci_pkg::BTN_LAMP);
		send_item(pfci_pkg::OP_PRESS, 16'd0, 1'b0, 1'b0, pfci_pkg::BTN_JETS_A);
		send_item(pfci_pkg::OP_PRESS, 16'd0, 1'b0, 1'b0, pfci_pkg::BTN_JETS_B);
		send_item(pfci_pkg::OP_PRESS, 16'hFFFF, 1'b1, 1'b1, pfci_pkg::BTN_AIR);
		send_item(pfci_pkg::OP_EDGE, 16'd0, 1'b1, 1'b0, pfci_pkg::BTN_NONE);
		send_item(pfci_pkg::OP_EDGE, 16'd0, 1'b0, 1'b1, pfci_pkg::BTN_AIR);

		run_random(200);

		settle();
		load_config(16'd0, 8'd0, 1'b1);
		run_random(250);

		settle();
		load_config(16'hFFFF, 8'hFF, 1'b1);
		run_random(250);

		settle();
		load_config(16'($urandom_range(0, 65535)), 8'd1, 1'b0);
		repeat (30) send_noise();

		settle();
		load_config(16'($urandom_range(50, 3000)), 8'($urandom_range(1, 3)), 1'b1);
		run_random(400);

		// receiver holds off while the sender keeps offering items back to back
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		rx_hold_req = 1'b1;
		send_frame();
		repeat (10) send_noise();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		settle();

		run_random(200);

		settle();
		load_config(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), 1'b1);
		run_random(150);

		settle();
		load_config(16'($urandom_range(100, 5000)), 8'($urandom_range(1, 4)), 1'b1);
		run_random(250);

		settle();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("panel_frame_capture_cmd_inject test passed");
		else
			$display("panel_frame_capture_cmd_inject test failed");
		$finish;
	end

endmodule
